// File: rtl/core/ipid_pkg.sv
// Shared types and constants for the incremental PID step unit.
package ipid_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int GAIN_W             = 16;
    localparam int TICK_W             = 16;
    localparam int ACC_W              = 32;
    localparam int CFG_INDEX_W        = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_INTEG_GAIN  = 2'd1,
        CFG_DERIV_GAIN  = 2'd2,
        CFG_FEED_OFFSET = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_ACC,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     calc_err;
        logic     calc_acc;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_init;
        logic     sum_add_prod;
        logic     div_init;
        logic     div_step;
        logic     sum_add_quo;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

endpackage

// File: rtl/core/incremental_pid_step_unit.sv
// A new input word is taken only in the idle state, after the previous update has been loaded into the output
// register; each update runs the one-bit-per-cycle divider
// over GAIN_W+SAMPLE_WIDTH+2 quotient bits after three passes of one multiplier.
// The next word is taken while a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears gains, feedforward, error sum, last error
// and the control state; the configuration port is always ready.
module incremental_pid_step_unit
    import ipid_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_prior_drive,
    input  logic signed [SAMPLE_WIDTH-1:0] s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0] s_target,
    input  logic [TICK_W-1:0]              s_elapsed_ticks,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_drive,
    output logic                           m_saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [GAIN_W-1:0]              cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ipid_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ipid_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_prior_drive   (s_prior_drive),
        .s_measured      (s_measured),
        .s_target        (s_target),
        .s_elapsed_ticks (s_elapsed_ticks),
        .m_drive         (m_drive),
        .m_saturated     (m_saturated)
    );

endmodule

// File: rtl/core/ipid_datapath.sv
// Datapath: input and gain registers, shared multiplier, divider, accumulator and output word.
module ipid_datapath
    import ipid_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dp_cmd_t                        cmd,
    output dp_status_t                     status,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [GAIN_W-1:0]              cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] s_prior_drive,
    input  logic signed [SAMPLE_WIDTH-1:0] s_measured,
    input  logic signed [SAMPLE_WIDTH-1:0] s_target,
    input  logic [TICK_W-1:0]              s_elapsed_ticks,
    output logic signed [SAMPLE_WIDTH-1:0] m_drive,
    output logic                           m_saturated
);

    localparam int SW       = SAMPLE_WIDTH;
    localparam int ERR_W    = SW + 1;
    localparam int DLT_W    = SW + 2;
    localparam int MB_W     = (DLT_W > ACC_W) ? DLT_W : ACC_W;
    localparam int PROD_W   = GAIN_W + MB_W;
    localparam int DIV_W    = GAIN_W + DLT_W;
    localparam int CNT_W    = $clog2(DIV_W);
    localparam int ACC_X_W  = ((ERR_W > ACC_W) ? ERR_W : ACC_W) + 2;
    localparam int SUM_B0   = (PROD_W > SW + GAIN_FRAC_BITS) ? PROD_W : SW + GAIN_FRAC_BITS;
    localparam int SUM_B1   = (SUM_B0 > GAIN_W + GAIN_FRAC_BITS) ? SUM_B0
                                                                 : GAIN_W + GAIN_FRAC_BITS;
    localparam int SUM_W    = SUM_B1 + 3;

    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg, kf_reg;
    logic signed [SW-1:0]     prior_reg, meas_reg, tgt_reg;
    logic [TICK_W-1:0]        ticks_reg;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ACC_W-1:0]  error_sum_reg, error_sum_next;
    logic signed [DLT_W-1:0]  delta_reg, delta_next;
    logic                     sat_reg, sat_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [TICK_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]         quo_reg, quo_next;
    logic                     qneg_reg, qneg_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SW-1:0]     drive_reg, drive_next;
    logic                     msat_reg, msat_next;

    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [ACC_X_W-1:0] acc_x;
    logic [ACC_X_W-ACC_W:0]    acc_hi;
    logic signed [PROD_W-1:0]  prod_mag;
    logic [TICK_W:0]           div_shift, div_trial;
    logic signed [SUM_W-1:0]   quo_ext, dterm, sh;
    logic [SUM_W-SW:0]         drv_hi;

    assign status.div_last = (cnt_reg == '0);
    assign m_drive         = drive_reg;
    assign m_saturated     = msat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            kf_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:   kp_reg <= cfg_data;
                CFG_INTEG_GAIN:  ki_reg <= cfg_data;
                CFG_DERIV_GAIN:  kd_reg <= cfg_data;
                CFG_FEED_OFFSET: kf_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        err_next       = err_reg;
        error_sum_next = error_sum_reg;
        delta_next     = delta_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qneg_next      = qneg_reg;
        cnt_next       = cnt_reg;
        drive_next     = drive_reg;
        msat_next      = msat_reg;

        acc_x  = ACC_X_W'(error_sum_reg) + ACC_X_W'(err_reg);
        acc_hi = acc_x[ACC_X_W-1:ACC_W-1];

        case (cmd.mul_sel)
            MUL_PROP: begin
                mul_a = kp_reg;
                mul_b = MB_W'(err_reg);
            end
            MUL_INTEG: begin
                mul_a = ki_reg;
                mul_b = MB_W'(error_sum_reg);
            end
            MUL_DERIV: begin
                mul_a = kd_reg;
                mul_b = MB_W'(delta_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        div_shift = {rem_reg, quo_reg[DIV_W-1]};
        div_trial = div_shift - {1'b0, ticks_reg};
        quo_ext   = SUM_W'($signed({1'b0, quo_reg}));
        dterm     = qneg_reg ? -quo_ext : quo_ext;
        sh        = sum_reg >>> GAIN_FRAC_BITS;
        drv_hi    = sh[SUM_W-1:SW-1];

        if (cmd.calc_err) begin
            err_next = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
            sat_next = 1'b0;
        end
        if (cmd.calc_acc) begin
            if ((&acc_hi) || !(|acc_hi)) begin
                error_sum_next = acc_x[ACC_W-1:0];
            end else begin
                error_sum_next = acc_x[ACC_X_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                  : {1'b0, {(ACC_W-1){1'b1}}};
                sat_next = 1'b1;
            end
            delta_next = DLT_W'(err_reg) - DLT_W'(last_error_reg);
        end
        if (cmd.mul_en) begin
            prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.sum_init) begin
            sum_next = (SUM_W'(prior_reg) + SUM_W'(kf_reg)) <<< GAIN_FRAC_BITS;
        end
        if (cmd.sum_add_prod) begin
            sum_next = sum_reg + SUM_W'(prod_reg);
        end
        if (cmd.div_init) begin
            rem_next  = '0;
            quo_next  = prod_mag[DIV_W-1:0];
            qneg_next = prod_reg[PROD_W-1];
            cnt_next  = CNT_W'(DIV_W - 1);
        end
        if (cmd.div_step) begin
            if (!div_trial[TICK_W]) begin
                rem_next = div_trial[TICK_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = div_shift[TICK_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.sum_add_quo) begin
            sum_next = sum_reg + dterm;
        end
        if (cmd.out_load) begin
            if ((&drv_hi) || !(|drv_hi)) begin
                drive_next = sh[SW-1:0];
                msat_next  = sat_reg;
            end else begin
                drive_next = sh[SUM_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                msat_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            cnt_reg        <= '0;
        end else begin
            error_sum_reg <= error_sum_next;
            cnt_reg       <= cnt_next;
            if (cmd.calc_acc) begin
                last_error_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            prior_reg <= s_prior_drive;
            meas_reg  <= s_measured;
            tgt_reg   <= s_target;
            ticks_reg <= (s_elapsed_ticks == '0) ? TICK_W'(1) : s_elapsed_ticks;
        end
        err_reg   <= err_next;
        delta_reg <= delta_next;
        sat_reg   <= sat_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        qneg_reg  <= qneg_next;
        drive_reg <= drive_next;
        msat_reg  <= msat_next;
    end

endmodule

// File: rtl/core/ipid_controller.sv
// Controller: sequences one update through the datapath and owns both handshakes.
module ipid_controller
    import ipid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_ERR;
            ST_ERR:      state_next = ST_ACC;
            ST_ACC:      state_next = ST_MUL_P;
            ST_MUL_P:    state_next = ST_MUL_I;
            ST_MUL_I:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (status.div_last) state_next = ST_FIN;
            ST_FIN:      state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MUL_PROP;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_ERR:   cmd.calc_err = 1'b1;
            ST_ACC:   cmd.calc_acc = 1'b1;
            ST_MUL_P: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_PROP;
                cmd.sum_init = 1'b1;
            end
            ST_MUL_I: begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_INTEG;
                cmd.sum_add_prod = 1'b1;
            end
            ST_MUL_D: begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_DERIV;
                cmd.sum_add_prod = 1'b1;
            end
            ST_DIV_INIT: cmd.div_init    = 1'b1;
            ST_DIV:      cmd.div_step    = 1'b1;
            ST_FIN:      cmd.sum_add_quo = 1'b1;
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
